FILE: src/gnos_pkg.sv
package gnos_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = $clog2(MAX_OCTAVES);
    localparam int CNT_W       = 4;
    localparam int GAIN_W      = 16;
    localparam int GRAD_W      = 15;
    localparam int PERM_W      = 8;
    localparam int POINT_W     = 32;
    localparam int NOISE_W     = 21;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] REG_OCTAVE_GAIN  = 2'd1;
    localparam logic [1:0] REG_TAKE_ABS     = 2'd2;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PERM, ST_SQ, ST_HERM, ST_SSTORE,
        ST_GRD, ST_DX, ST_DY, ST_DZ, ST_WXY, ST_WALL, ST_TOT, ST_ACC,
        ST_CONTR, ST_SUM, ST_AMP, ST_FINAL
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_START, OP_PERM_RD, OP_SQ, OP_HERM, OP_SSTORE,
        OP_GRD_RD, OP_DX, OP_DY, OP_DZ, OP_WXY, OP_WALL, OP_TOT, OP_ACC,
        OP_CONTR, OP_SUM, OP_AMP, OP_FINAL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic       half;
        logic [2:0] corner;
    } t_cmd;

endpackage

FILE: src/gnos_ctrl.sv
module gnos_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_req_type,
    input  logic [gnos_pkg::CNT_W-1:0] i_octave_count,
    input  logic                  i_out_stall,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output gnos_pkg::t_cmd        o_cmd
);
    import gnos_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_axis;
    logic              r_half;
    logic [2:0]        r_corner;
    logic [OCT_W-1:0]  r_oct;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic              accept;
    logic              out_free;
    logic              last_oct;
    logic [CNT_W-1:0]  cnt_sat;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_oct = (CNT_W'(r_oct) + CNT_W'(1)) == r_cnt;
    assign cnt_sat  = (i_octave_count > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                             : i_octave_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type == REQ_EVAL) begin
                    n_state = (cnt_sat == '0) ? ST_FINAL : ST_PERM;
                end
            end
            ST_PERM:   if (r_axis == 2'd2 && r_half) n_state = ST_SQ;
            ST_SQ:     n_state = ST_HERM;
            ST_HERM:   n_state = ST_SSTORE;
            ST_SSTORE: n_state = (r_axis == 2'd2) ? ST_GRD : ST_SQ;
            ST_GRD:    n_state = ST_DX;
            ST_DX:     n_state = ST_DY;
            ST_DY:     n_state = ST_DZ;
            ST_DZ:     n_state = ST_WXY;
            ST_WXY:    n_state = ST_WALL;
            ST_WALL:   n_state = ST_TOT;
            ST_TOT:    n_state = ST_ACC;
            ST_ACC:    n_state = (r_corner == 3'd7) ? ST_CONTR : ST_GRD;
            ST_CONTR:  n_state = ST_SUM;
            ST_SUM:    n_state = ST_AMP;
            ST_AMP:    n_state = last_oct ? ST_FINAL : ST_PERM;
            ST_FINAL:  if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.axis   = r_axis;
        o_cmd.half   = r_half;
        o_cmd.corner = r_corner;
        o_cmd.op     = OP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) o_cmd.op = (i_req_type == REQ_EVAL) ? OP_START : OP_LOAD;
            end
            ST_PERM:   o_cmd.op = OP_PERM_RD;
            ST_SQ:     o_cmd.op = OP_SQ;
            ST_HERM:   o_cmd.op = OP_HERM;
            ST_SSTORE: o_cmd.op = OP_SSTORE;
            ST_GRD:    o_cmd.op = OP_GRD_RD;
            ST_DX:     o_cmd.op = OP_DX;
            ST_DY:     o_cmd.op = OP_DY;
            ST_DZ:     o_cmd.op = OP_DZ;
            ST_WXY:    o_cmd.op = OP_WXY;
            ST_WALL:   o_cmd.op = OP_WALL;
            ST_TOT:    o_cmd.op = OP_TOT;
            ST_ACC:    o_cmd.op = OP_ACC;
            ST_CONTR:  o_cmd.op = OP_CONTR;
            ST_SUM:    o_cmd.op = OP_SUM;
            ST_AMP:    o_cmd.op = OP_AMP;
            ST_FINAL:  if (out_free) o_cmd.op = OP_FINAL;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= '0;
            r_half      <= 1'b0;
            r_corner    <= '0;
            r_oct       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && accept) begin
                r_cnt  <= cnt_sat;
                r_oct  <= '0;
                r_axis <= '0;
                r_half <= 1'b0;
            end
            if (r_state == ST_PERM) begin
                r_half <= !r_half;
                if (r_half) r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
            if (r_state == ST_SSTORE) begin
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
            if (r_state == ST_ACC) r_corner <= r_corner + 3'd1;
            if (r_state == ST_AMP) r_oct <= r_oct + OCT_W'(1);
            // Hold the result until taken; load a new one from the final step
            if (r_state == ST_FINAL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/gnos_dpath.sv
module gnos_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gnos_pkg::t_cmd                    i_cmd,
    input  logic [gnos_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [gnos_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnos_pkg::GRAD_W-1:0] i_grad_y,
    input  logic signed [gnos_pkg::GRAD_W-1:0] i_grad_z,
    input  logic [gnos_pkg::PERM_W-1:0]       i_perm_x_value,
    input  logic [gnos_pkg::PERM_W-1:0]       i_perm_y_value,
    input  logic [gnos_pkg::PERM_W-1:0]       i_perm_z_value,
    input  logic signed [gnos_pkg::POINT_W-1:0] i_point_x,
    input  logic signed [gnos_pkg::POINT_W-1:0] i_point_y,
    input  logic signed [gnos_pkg::POINT_W-1:0] i_point_z,
    input  logic [gnos_pkg::GAIN_W-1:0]       i_octave_gain,
    input  logic                              i_take_absolute,
    output logic signed [gnos_pkg::NOISE_W-1:0] o_noise_value
);
    import gnos_pkg::*;

    localparam int PW = IDX_W + 16;   // point bits that reach index and fraction
    localparam int GE = 3 * GRAD_W;
    localparam int PE = 3 * PERM_W;

    logic [GE-1:0]        grad_mem [TABLE_SIZE];
    logic [PE-1:0]        perm_mem [TABLE_SIZE];
    logic [GE-1:0]        r_grd_q;
    logic [PE-1:0]        r_perm_q;
    logic [IDX_W-1:0]     r_pv [6];
    logic                 r_cap;
    logic [2:0]           r_cap_sel;
    logic [1:0]           r_cap_axis;

    logic [PW-1:0]        r_p [3];
    logic [16:0]          r_s [3];
    logic signed [54:0]   r_prod;
    logic signed [35:0]   r_dp;
    logic signed [55:0]   r_total;
    logic signed [31:0]   r_sum;
    logic [16:0]          r_amp;
    logic signed [NOISE_W-1:0] r_noise;

    logic signed [35:0]   m_a;
    logic signed [18:0]   m_b;
    logic [15:0]          f_ax;
    logic [IDX_W-1:0]     rd_perm_addr;
    logic [IDX_W-1:0]     gsel;
    logic                 bx, by, bz;
    logic [16:0]          wx, wy, wz;
    logic signed [16:0]   off_x, off_y, off_z;
    logic [16:0]          rnd16;
    logic [16:0]          herm_s;
    logic signed [55:0]   tot_rnd;
    logic signed [25:0]   n_oct;
    logic signed [54:0]   contr_rnd;
    logic signed [31:0]   sum_abs;
    logic signed [NOISE_W-1:0] sat;

    assign bx = i_cmd.corner[2];
    assign by = i_cmd.corner[1];
    assign bz = i_cmd.corner[0];

    assign f_ax         = r_p[i_cmd.axis][15:0];
    assign rd_perm_addr = r_p[i_cmd.axis][PW-1:16] + IDX_W'(i_cmd.half);
    assign gsel = r_pv[{2'd0, bx}] ^ r_pv[{2'd1, by}] ^ r_pv[{2'd2, bz}];

    assign wx = bx ? r_s[0] : 17'd65536 - r_s[0];
    assign wy = by ? r_s[1] : 17'd65536 - r_s[1];
    assign wz = bz ? r_s[2] : 17'd65536 - r_s[2];
    assign off_x = {bx, r_p[0][15:0]};
    assign off_y = {by, r_p[1][15:0]};
    assign off_z = {bz, r_p[2][15:0]};

    assign rnd16     = 17'((r_prod + 55'sd32768) >>> 16);
    assign herm_s    = 17'((r_prod + 55'sd2147483648) >>> 32);
    assign tot_rnd   = (r_total + 56'sd536870912) >>> 30;
    assign n_oct     = tot_rnd[25:0];
    assign contr_rnd = (r_prod + 55'sd32768) >>> 16;

    // Shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_SQ: begin
                m_a = 36'(f_ax);
                m_b = 19'(f_ax);
            end
            OP_HERM: begin
                m_a = 36'(r_prod[31:0]);
                m_b = 19'(18'd196608 - {1'b0, f_ax, 1'b0});
            end
            OP_DX: begin
                m_a = 36'(off_x);
                m_b = 19'(signed'(r_grd_q[GRAD_W-1:0]));
            end
            OP_DY: begin
                m_a = 36'(off_y);
                m_b = 19'(signed'(r_grd_q[2*GRAD_W-1:GRAD_W]));
            end
            OP_DZ: begin
                m_a = 36'(off_z);
                m_b = 19'(signed'(r_grd_q[3*GRAD_W-1:2*GRAD_W]));
            end
            OP_WXY: begin
                m_a = 36'(wx);
                m_b = 19'(wy);
            end
            OP_WALL: begin
                m_a = 36'(rnd16);
                m_b = 19'(wz);
            end
            OP_TOT: begin
                m_a = r_dp;
                m_b = 19'(rnd16);
            end
            OP_CONTR: begin
                m_a = 36'(n_oct);
                m_b = 19'(r_amp);
            end
            OP_SUM: begin
                m_a = 36'(r_amp);
                m_b = 19'(i_octave_gain);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Final shaping: optional absolute value, then clamp to the output range
    always_comb begin
        sum_abs = (i_take_absolute && r_sum < 0) ? -r_sum : r_sum;
        if (sum_abs > 32'sd1048575)       sat = NOISE_W'(32'sd1048575);
        else if (sum_abs < -32'sd1048576) sat = NOISE_W'(-32'sd1048576);
        else                              sat = sum_abs[NOISE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            grad_mem[i_entry_index] <= {i_grad_z, i_grad_y, i_grad_x};
            perm_mem[i_entry_index] <= {i_perm_z_value, i_perm_y_value, i_perm_x_value};
        end
        if (i_cmd.op == OP_PERM_RD) r_perm_q <= perm_mem[rd_perm_addr];
        if (i_cmd.op == OP_GRD_RD)  r_grd_q  <= grad_mem[gsel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b0;
        end else begin
            r_cap <= (i_cmd.op == OP_PERM_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_sel  <= {i_cmd.axis, i_cmd.half};
        r_cap_axis <= i_cmd.axis;
        if (r_cap) begin
            case (r_cap_axis)
                2'd0:    r_pv[r_cap_sel] <= r_perm_q[PERM_W-1:0];
                2'd1:    r_pv[r_cap_sel] <= r_perm_q[2*PERM_W-1:PERM_W];
                default: r_pv[r_cap_sel] <= r_perm_q[3*PERM_W-1:2*PERM_W];
            endcase
        end
        r_prod <= m_a * m_b;
        case (i_cmd.op)
            OP_START: begin
                r_p[0] <= i_point_x[PW-1:0];
                r_p[1] <= i_point_y[PW-1:0];
                r_p[2] <= i_point_z[PW-1:0];
                r_sum  <= '0;
                r_amp  <= 17'd65536;
            end
            OP_SSTORE: r_s[i_cmd.axis] <= herm_s;
            OP_DY:     r_dp <= r_prod[35:0];
            OP_DZ:     r_dp <= r_dp + r_prod[35:0];
            OP_WXY:    r_dp <= r_dp + r_prod[35:0];
            OP_ACC: begin
                if (i_cmd.corner == 3'd0) r_total <= 56'(r_prod);
                else                      r_total <= r_total + 56'(r_prod);
            end
            OP_SUM:    r_sum <= r_sum + contr_rnd[31:0];
            OP_AMP: begin
                r_amp  <= rnd16;
                r_p[0] <= {r_p[0][PW-2:0], 1'b0};
                r_p[1] <= {r_p[1][PW-2:0], 1'b0};
                r_p[2] <= {r_p[2][PW-2:0], 1'b0};
            end
            OP_FINAL:  r_noise <= sat;
            default: ;
        endcase
    end

    assign o_noise_value = r_noise;

endmodule

FILE: src/gradient_noise_octave_sum.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// input    | i_in_valid / o_in_stall    | req_type, entry_index, grad, perm, point
// output   | o_out_valid / i_out_stall  | noise_value (one per evaluate item)
// config   | APB psel/penable/pwrite    | octave_count, octave_gain, take_absolute
//
// A load item writes one table entry as it is taken; the block stays ready.
// An evaluate item runs its N octaves one after another: each octave
// reads six permutation words and eight gradient words through one read port per table,
// and every product goes through one shared multiplier, one per cycle.
// Reset is synchronous and active low; it clears control state, not the tables.
// A result waits in the output register under stall while the next item is taken.
module gradient_noise_octave_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_entry_index,
    input  logic signed [14:0] i_grad_x,
    input  logic signed [14:0] i_grad_y,
    input  logic signed [14:0] i_grad_z,
    input  logic [7:0]  i_perm_x_value,
    input  logic [7:0]  i_perm_y_value,
    input  logic [7:0]  i_perm_z_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [20:0] o_noise_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gnos_pkg::*;

    logic [CNT_W-1:0]  r_octave_count;
    logic [GAIN_W-1:0] r_octave_gain;
    logic              r_take_abs;
    logic              cfg_wr;
    t_cmd              cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register file: write only between items, gain and sign mode are read live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= CNT_W'(1);
            r_octave_gain  <= GAIN_W'(32768);
            r_take_abs     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_OCTAVE_COUNT: r_octave_count <= pwdata[CNT_W-1:0];
                REG_OCTAVE_GAIN:  r_octave_gain  <= pwdata[GAIN_W-1:0];
                REG_TAKE_ABS:     r_take_abs     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OCTAVE_COUNT: prdata = 32'(r_octave_count);
            REG_OCTAVE_GAIN:  prdata = 32'(r_octave_gain);
            REG_TAKE_ABS:     prdata = 32'(r_take_abs);
            default:          prdata = '0;
        endcase
    end

    gnos_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_req_type     (i_req_type),
        .i_octave_count (r_octave_count),
        .i_out_stall    (i_out_stall),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_cmd          (cmd)
    );

    gnos_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_entry_index   (i_entry_index),
        .i_grad_x        (i_grad_x),
        .i_grad_y        (i_grad_y),
        .i_grad_z        (i_grad_z),
        .i_perm_x_value  (i_perm_x_value),
        .i_perm_y_value  (i_perm_y_value),
        .i_perm_z_value  (i_perm_z_value),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_octave_gain   (r_octave_gain),
        .i_take_absolute (r_take_abs),
        .o_noise_value   (o_noise_value)
    );

    // An evaluate item with octaves to sum keeps the input side busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == REQ_EVAL && r_octave_count != '0)
        |=> o_in_stall)
        else $error("evaluate item did not start work");

    // A load item leaves the block ready for the next item
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == REQ_LOAD) |=> !o_in_stall)
        else $error("load item blocked the input");

    // A new result only appears at the end of an evaluation
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an evaluation");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gnos_pkg::*;

    // One item on the input channel
    typedef struct {
        logic                     req;
        logic [7:0]               entry;
        logic signed [14:0]       gx, gy, gz;
        logic [7:0]               px_perm, py_perm, pz_perm;
        logic signed [31:0]       x, y, z;
    } noise_req_t;

    // Directed row: the item and, where it is plain, the value it must give
    typedef struct {
        noise_req_t               it;
        bit                       fixed;
        logic signed [20:0]       value;
    } directed_row_t;

    // One configuration setting and how many items run under it
    typedef struct {
        int unsigned              count;
        int unsigned              gain;
        int unsigned              absval;
        int unsigned              items;
        int unsigned              fill;   // 0 keep table, 1 random refill, 2 extreme gradients
    } phase_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = REQ_LOAD;
    logic [7:0]         i_entry_index = '0;
    logic signed [14:0] i_grad_x = '0, i_grad_y = '0, i_grad_z = '0;
    logic [7:0]         i_perm_x_value = '0, i_perm_y_value = '0, i_perm_z_value = '0;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [20:0] o_noise_value;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    gradient_noise_octave_sum dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's tables and registers
    longint             grad_tab [256][3];
    int unsigned        perm_tab [256][3];
    int unsigned        cfg_count = 1, cfg_gain = 32768, cfg_abs = 0;

    logic signed [20:0] noise_q [$];   // noise values still owed by the block
    int                 errors = 0;
    int                 n_loads = 0, n_evals = 0, n_results = 0, n_clipped = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_req = 1'b0;
    int unsigned        hold_len = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint hermite_q16(input longint f);
        return (f * f * (196608 - 2 * f) + (longint'(1) << 31)) >>> 32;
    endfunction

    // Noise of one octave at a Q.16 point, result in Q.16
    function automatic longint octave_value(input longint px, input longint py, input longint pz);
        longint pos [3];
        longint cidx [3], fr [3], sm [3], wt [3];
        longint total, dp, wxy, wall, sel;
        int     cn, ax, bit_c;
        pos[0] = px; pos[1] = py; pos[2] = pz;
        total = 0;
        for (ax = 0; ax < 3; ax++) begin
            cidx[ax] = pos[ax] >>> 16;
            fr[ax]   = pos[ax] & 64'hFFFF;
            sm[ax]   = hermite_q16(fr[ax]);
        end
        for (cn = 0; cn < 8; cn++) begin
            sel = 0;
            dp  = 0;
            for (ax = 0; ax < 3; ax++) begin
                bit_c = (cn >> (2 - ax)) & 1;
                sel   = sel ^ perm_tab[(cidx[ax] + bit_c) & 255][ax];
                wt[ax] = bit_c ? sm[ax] : 65536 - sm[ax];
            end
            sel = sel & 255;
            for (ax = 0; ax < 3; ax++) begin
                bit_c = (cn >> (2 - ax)) & 1;
                dp += grad_tab[sel][ax] * (fr[ax] - (bit_c ? 65536 : 0));
            end
            wxy  = (wt[0] * wt[1] + 32768) >>> 16;
            wall = (wxy * wt[2] + 32768) >>> 16;
            total += dp * wall;
        end
        return (total + (longint'(1) << 29)) >>> 30;
    endfunction

    // Full octave sum with gain, absolute value and clipping
    function automatic logic signed [20:0] octave_sum(input noise_req_t it);
        longint      sum, amp, n;
        int unsigned cnt, oc;
        sum = 0;
        amp = 65536;
        cnt = (cfg_count > MAX_OCTAVES) ? MAX_OCTAVES : cfg_count;
        for (oc = 0; oc < cnt; oc++) begin
            n = octave_value(longint'(it.x) <<< oc, longint'(it.y) <<< oc,
                             longint'(it.z) <<< oc);
            sum += (n * amp + 32768) >>> 16;
            amp = (amp * cfg_gain + 32768) >>> 16;
        end
        if (cfg_abs != 0 && sum < 0)
            sum = -sum;
        if (sum > 1048575 || sum < -1048576)
            n_clipped++;
        if (sum > 1048575)
            sum = 1048575;
        if (sum < -1048576)
            sum = -1048576;
        return sum[20:0];
    endfunction

    // Apply one accepted item to the shadow state and owe its result
    task automatic apply_item(input noise_req_t it, input bit fixed,
                              input logic signed [20:0] value);
        if (it.req == REQ_LOAD) begin
            grad_tab[it.entry][0] = longint'(it.gx);
            grad_tab[it.entry][1] = longint'(it.gy);
            grad_tab[it.entry][2] = longint'(it.gz);
            perm_tab[it.entry][0] = 32'(it.px_perm);
            perm_tab[it.entry][1] = 32'(it.py_perm);
            perm_tab[it.entry][2] = 32'(it.pz_perm);
            n_loads++;
        end else begin
            noise_q.push_back(fixed ? value : octave_sum(it));
            n_evals++;
        end
    endtask

    // Offer one item; hold it until the block takes it
    task automatic send_item(input noise_req_t it, input bit fixed,
                             input logic signed [20:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_req_type     <= it.req;
        i_entry_index  <= it.entry;
        i_grad_x       <= it.gx;
        i_grad_y       <= it.gy;
        i_grad_z       <= it.gz;
        i_perm_x_value <= it.px_perm;
        i_perm_y_value <= it.py_perm;
        i_perm_z_value <= it.pz_perm;
        i_point_x      <= it.x;
        i_point_y      <= it.y;
        i_point_z      <= it.z;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(it, fixed, value);
        @(negedge i_clk);
    endtask

    function automatic noise_req_t random_item(input bit want_load, input int unsigned fill);
        noise_req_t it;
        int unsigned pick;
        it.req     = want_load ? REQ_LOAD : REQ_EVAL;
        it.entry   = 8'($urandom);
        it.gx      = 15'($urandom);
        it.gy      = 15'($urandom);
        it.gz      = 15'($urandom);
        if (fill == 2) begin
            // extreme gradients push the sum toward clipping
            it.gx = $urandom_range(0, 1) ? 15'sd16383 : 15'sh4000;
            it.gy = $urandom_range(0, 1) ? 15'sd16383 : 15'sh4000;
            it.gz = $urandom_range(0, 1) ? 15'sd16383 : 15'sh4000;
        end
        it.px_perm = 8'($urandom);
        it.py_perm = 8'($urandom);
        it.pz_perm = 8'($urandom);
        pick = $urandom_range(0, 9);
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        if (pick < 5) begin
            // points near the origin, where most texture lookups live
            it.x = $signed(it.x) >>> 10;
            it.y = $signed(it.y) >>> 10;
            it.z = $signed(it.z) >>> 10;
        end else if (pick == 5) begin
            it.x[15:0] = '0;
            it.y[15:0] = '0;
            it.z[15:0] = '0;
        end
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OCTAVE_COUNT: begin
                cfg_count = val & 32'hF;
            end
            REG_OCTAVE_GAIN: begin
                cfg_gain = val & 32'hFFFF;
            end
            default: begin
                cfg_abs = val & 32'h1;
            end
        endcase
    endtask

    // Drain all owed results, then cover the worst-case tail of a long evaluate
    task automatic wait_drained();
        while (noise_q.size() != 0)
            @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: compare every accepted result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (noise_q.size() == 0) begin
                report_mismatch("unexpected noise_value", o_noise_value, 0);
            end else begin
                if (o_noise_value !== noise_q[0])
                    report_mismatch("noise_value", o_noise_value, noise_q[0]);
                void'(noise_q.pop_front());
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hard limit on run time
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic noise_req_t mk(input logic req, input logic [7:0] e,
                                      input int gx, input int gy, input int gz,
                                      input int unsigned p0, input int unsigned p1,
                                      input int unsigned p2,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
        noise_req_t it;
        it.req = req; it.entry = e;
        it.gx = 15'(gx); it.gy = 15'(gy); it.gz = 15'(gz);
        it.px_perm = 8'(p0); it.py_perm = 8'(p1); it.pz_perm = 8'(p2);
        it.x = x; it.y = y; it.z = z;
        return it;
    endfunction

    initial begin
        directed_row_t rows [$];
        phase_t        phases [$];
        noise_req_t    it;
        int            r, p, k;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load every entry first: the block must never read an unwritten one
        for (k = 0; k < 256; k++) begin
            it = random_item(1'b1, 1);
            it.entry = 8'(k);
            send_item(it, 1'b0, '0);
        end

        // Directed rows under reset settings (one octave, signed sum).
        // Integer points sit on a cell corner, so every octave gives zero.
        rows.push_back('{mk(REQ_LOAD, 8'd0, 16383, -16384, 0, 255, 0, 170,
                            32'h7FFFFFFF, 32'h80000000, 32'h1), 1'b0, '0});
        rows.push_back('{mk(REQ_LOAD, 8'd255, -16384, 16383, -1, 0, 255, 85,
                            0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h0, 32'h0, 32'h0), 1'b1, 21'sd0});
        rows.push_back('{mk(REQ_EVAL, 8'd255, 16383, -16384, 16383, 255, 255, 255,
                            32'h7FFF0000, 32'h80000000, 32'h00010000), 1'b1, 21'sd0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h80000000, 32'h80000000, 32'h80000000), 1'b1, 21'sd0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'hFFFF0000, 32'h00FF0000, 32'h7FFF0000), 1'b1, 21'sd0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'hFFFFFFFF, 32'h1, 32'h8000), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h8000, 32'h8000, 32'h8000), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h80000001, 32'hFFFF7FFF, 32'h0000C000), 1'b0, '0});
        rows.push_back('{mk(REQ_LOAD, 8'd128, 0, 0, 0, 0, 0, 0,
                            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd128, 0, 0, 0, 0, 0, 0,
                            32'h00804000, 32'hFF7F2000, 32'h00001234), 1'b0, '0});
        rows.push_back('{mk(REQ_LOAD, 8'd255, 0, 0, 0, 128, 1, 254,
                            0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(REQ_EVAL, 8'd0, 0, 0, 0, 0, 0, 0,
                            32'h00FFFFFF, 32'hFF00FFFF, 32'hFFFFFFFF), 1'b0, '0});
        for (r = 0; r < rows.size(); r++)
            send_item(rows[r].it, rows[r].fixed, rows[r].value);
        i_in_valid <= 1'b0;
        wait_drained();

        // Settings walk, extremes included; count 15 exercises the octave clamp
        phases.push_back('{1, 32768, 0, 150, 0});
        phases.push_back('{2, 40000, 1, 130, 0});
        phases.push_back('{0, 0, 1, 40, 0});
        phases.push_back('{3, 20000, 0, 110, 0});
        phases.push_back('{15, 65535, 1, 40, 2});
        phases.push_back('{8, 0, 0, 30, 1});
        phases.push_back('{1, 65535, 1, 90, 0});
        phases.push_back('{4, 12345, 0, 80, 0});
        phases.push_back('{2, 32768, 0, 150, 0});

        for (p = 0; p < phases.size(); p++) begin
            write_reg(REG_OCTAVE_COUNT, phases[p].count);
            write_reg(REG_OCTAVE_GAIN, phases[p].gain);
            write_reg(REG_TAKE_ABS, phases[p].absval);
            if (phases[p].fill != 0) begin
                for (k = 0; k < 256; k++) begin
                    it = random_item(1'b1, phases[p].fill);
                    it.entry = 8'(k);
                    send_item(it, 1'b0, '0);
                end
            end
            // last phase runs flat out on both sides
            idle_on = (p != phases.size() - 1);
            for (k = 0; k < phases[p].items; k++) begin
                // back up the output while evaluates keep arriving
                if (p == 1 && k == 20) begin
                    hold_len = 3000;
                    hold_req = 1'b1;
                end
                it = random_item($urandom_range(0, 3) == 0, phases[p].fill);
                send_item(it, 1'b0, '0);
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        $display("Ran %0d table loads and %0d noise evaluations (%0d results, %0d clipped)",
                 n_loads, n_evals, n_results, n_clipped);
        $display("Octave counts 0..15, gains 0..65535, signed and absolute sums covered");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: gradient_noise_octave_sum.f
src/gnos_pkg.sv
src/gnos_ctrl.sv
src/gnos_dpath.sv
src/gradient_noise_octave_sum.sv
tb/tb_top.sv
